// File: rtl/core/sb2d_pkg.sv
// Shared types, symbol codes and place-value constants for the signed
// binary to decimal digit converter. No dependencies.
package sb2d_pkg;

    localparam int unsigned NUM_PLACES = 10;
    localparam int unsigned IDX_W      = 4;
    localparam int unsigned MAG_W      = 32;
    localparam int unsigned PROD_W     = 36;
    localparam int unsigned RADIX      = 10;

    localparam logic [7:0] SYM_MINUS = 8'hCC;
    localparam logic [7:0] SYM_END   = 8'hFF;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PLACES - 1);

    typedef struct packed {
        logic [MAG_W-1:0]                  rem;
        logic [NUM_PLACES-1:0][3:0]        digits;
        logic                              neg;
        logic                              pad;
        logic                              seen;
        logic [IDX_W-1:0]                  start;
    } sb2d_word_t;

    // Place value 10^(9-k), index 0 is the most significant place.
    function automatic logic [MAG_W-1:0] place_value(input int unsigned k);
        logic [MAG_W-1:0] p;
        case (k)
            0:       p = 32'd1000000000;
            1:       p = 32'd100000000;
            2:       p = 32'd10000000;
            3:       p = 32'd1000000;
            4:       p = 32'd100000;
            5:       p = 32'd10000;
            6:       p = 32'd1000;
            7:       p = 32'd100;
            8:       p = 32'd10;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

    function automatic logic [PROD_W-1:0] digit_mult(input int unsigned k,
                                                     input int unsigned d);
        logic [PROD_W-1:0] m;
        m = PROD_W'(place_value(k)) * PROD_W'(d);
        return m;
    endfunction

endpackage

// File: rtl/core/sb2d_cell.sv
// One decimal place of the digit chain: extracts the digit for its place,
// passes the remainder on. Depends on sb2d_pkg.
module sb2d_cell #(
    parameter int unsigned INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sb2d_pkg::sb2d_word_t in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output sb2d_pkg::sb2d_word_t out_word
);

    logic                 valid_reg;
    sb2d_pkg::sb2d_word_t word_reg;
    sb2d_pkg::sb2d_word_t word_next;
    logic [3:0]           dig;
    logic [sb2d_pkg::PROD_W-1:0] sub;
    logic [sb2d_pkg::PROD_W-1:0] rem_wide;

    always_comb
    begin
        rem_wide = sb2d_pkg::PROD_W'(in_word.rem);
        dig      = 4'd0;
        sub      = '0;
        for (int unsigned d = 1; d < sb2d_pkg::RADIX; d++)
        begin
            if (rem_wide >= sb2d_pkg::digit_mult(INDEX, d))
            begin
                dig = 4'(d);
                sub = sb2d_pkg::digit_mult(INDEX, d);
            end
        end
        word_next            = in_word;
        word_next.rem        = sb2d_pkg::MAG_W'(rem_wide - sub);
        word_next.digits[INDEX] = dig;
        if (!in_word.seen && (dig != 4'd0 || in_word.pad ||
                              INDEX == sb2d_pkg::NUM_PLACES - 1))
        begin
            word_next.seen  = 1'b1;
            word_next.start = sb2d_pkg::IDX_W'(INDEX);
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= word_next;
        end
    end

endmodule

// File: rtl/core/sb2d_serializer.sv
// Output sequencer: turns one finished digit word into its symbol run,
// one symbol per cycle while the receiver is ready. Depends on sb2d_pkg.
module sb2d_serializer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sb2d_pkg::sb2d_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           symbol,
    output logic                 last
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SIGN  = 2'd1;
    localparam logic [1:0] ST_DIGIT = 2'd2;
    localparam logic [1:0] ST_END   = 2'd3;

    logic [1:0]                           state_reg;
    logic [1:0]                           state_next;
    logic [sb2d_pkg::IDX_W-1:0]           idx_reg;
    logic [sb2d_pkg::IDX_W-1:0]           idx_next;
    logic [sb2d_pkg::NUM_PLACES-1:0][3:0] digits_reg;
    logic                                 load;

    assign in_ready  = (state_reg == ST_IDLE) || (state_reg == ST_END && out_ready);
    assign load      = in_valid && in_ready;
    assign out_valid = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_SIGN:
            begin
                if (out_ready)
                begin
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == sb2d_pkg::LAST_IDX)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_END:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (load)
        begin
            state_next = in_word.neg ? ST_SIGN : ST_DIGIT;
            idx_next   = in_word.start;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SIGN:  symbol = sb2d_pkg::SYM_MINUS;
            ST_DIGIT: symbol = {4'd0, digits_reg[idx_reg]};
            ST_END:   symbol = sb2d_pkg::SYM_END;
            default:  symbol = 8'd0;
        endcase
    end

    assign last = (state_reg == ST_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            digits_reg <= in_word.digits;
        end
    end

`ifndef SYNTHESIS
    a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> symbol == sb2d_pkg::SYM_END)
        else $error("last flagged on a non-end symbol");

    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIGIT |-> idx_reg <= sb2d_pkg::LAST_IDX && digits_reg[idx_reg] <= 4'd9)
        else $error("digit index or value out of range");

    a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && state_reg == ST_SIGN |=> state_reg == ST_DIGIT)
        else $error("minus symbol not followed by a digit");

    a_no_load_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIGN || state_reg == ST_DIGIT) |-> !in_ready)
        else $error("new request taken while a run is in progress");
`endif

endmodule

// File: rtl/core/signed_binary_to_decimal_digits_core.sv
// Top level of the signed binary to decimal digit converter: a chain of
// ten digit cells followed by the symbol sequencer.
// Depends on sb2d_pkg, sb2d_cell and sb2d_serializer.
//
// Input channel (in_valid/in_ready): one request carries number, a signed
// 32-bit value, and pad_zeros. Output channel (out_valid/out_ready): one
// symbol per cycle while out_ready is high, digit values 0-9, 204 for a
// leading minus, 255 for the end marker flagged with last.
// Each request passes through ten registered cells, one per decimal place,
// that take out the place's digit and hand the remainder on; then the
// sequencer loads it into its state register and emits the run. A run has
// 2 to 12 symbols; the sequencer takes the next request only as it sends
// the end marker of the current run, and up to ten further requests wait
// in the cell chain meanwhile.
// Reset empties the chain and returns the sequencer to idle. When the
// receiver stalls, the current symbol holds and the chain fills, then
// in_ready drops.
module signed_binary_to_decimal_digits_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] number,
    input  logic               pad_zeros,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         symbol,
    output logic               last
);

    localparam int unsigned N = sb2d_pkg::NUM_PLACES;

    logic                 chain_valid [N+1];
    logic                 chain_ready [N+1];
    sb2d_pkg::sb2d_word_t chain_word  [N+1];
    logic [31:0]          raw;

    assign raw = $unsigned(number);

    always_comb
    begin
        chain_word[0]        = '0;
        chain_word[0].neg    = raw[31];
        chain_word[0].rem    = raw[31] ? (~raw + 32'd1) : raw;
        chain_word[0].pad    = pad_zeros;
    end

    assign chain_valid[0] = in_valid;
    assign in_ready       = chain_ready[0];

    for (genvar k = 0; k < N; k++)
    begin : g_cell
        sb2d_cell #(
            .INDEX(k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_word   (chain_word[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_word  (chain_word[k+1])
        );
    end

    sb2d_serializer u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[N]),
        .in_ready  (chain_ready[N]),
        .in_word   (chain_word[N]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

endmodule

// File: tb/sv/sb2d_digit_checker.sv
// Checker for signed_binary_to_decimal_digits_core: predicts the symbol run of each
// accepted request and compares it with the symbols that leave the output channel.
// Depends on sb2d_pkg.
module sb2d_digit_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] number,
    input  logic               pad_zeros,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [7:0]         symbol,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 symbols_checked
);

    localparam logic [31:0] TOP_PLACE = 32'd1000000000;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } digit_sym_t;

    digit_sym_t expected_symbols[$];
    int         mismatches = 0;
    int         checked = 0;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void queue_symbol(input logic [7:0] sym, input logic is_last);
        digit_sym_t s;
        s.symbol = sym;
        s.last   = is_last;
        expected_symbols.push_back(s);
    endfunction

    function automatic void predict_digit_run(input logic signed [31:0] value,
                                              input logic pad);
        logic [31:0] mag;
        logic [31:0] place;
        logic [31:0] d;
        logic        keep;
        keep = pad;
        mag  = value;
        if (value[31])
        begin
            mag = ~value + 32'd1;
            queue_symbol(sb2d_pkg::SYM_MINUS, 1'b0);
        end
        place = TOP_PLACE;
        while (place != 32'd0)
        begin
            d = mag / place;
            if (d != 32'd0 || keep || place == 32'd1)
            begin
                keep = 1'b1;
                queue_symbol(8'(d % sb2d_pkg::RADIX), 1'b0);
            end
            place = place / sb2d_pkg::RADIX;
        end
        queue_symbol(sb2d_pkg::SYM_END, 1'b1);
    endfunction

    always @(posedge clk)
    begin
        digit_sym_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                checked++;
                if (expected_symbols.size() == 0)
                begin
                    report_mismatch("unexpected symbol", symbol, 8'd0);
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (symbol !== want.symbol)
                        report_mismatch("symbol", symbol, want.symbol);
                    if (last !== want.last)
                        report_mismatch("last", 8'(last), 8'(want.last));
                end
            end
            if (in_valid && in_ready)
                predict_digit_run(number, pad_zeros);
        end
        pending         <= expected_symbols.size();
        fail_count      <= mismatches;
        symbols_checked <= checked;
    end

endmodule

// File: tb/sv/testbench.sv
// Top of the testbench for signed_binary_to_decimal_digits_core: clock, reset and
// request stimulus over four idle/stall phases, verdict at the end.
// Depends on sb2d_pkg, the core RTL and sb2d_digit_checker.
module testbench;

    localparam int PHASE_ITEMS    = 76;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 30;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] number = '0;
    logic               pad_zeros = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         symbol;
    logic               last;

    int fail_count;
    int pending;
    int symbols_checked;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int requests_sent = 0;
    int directed_sent = 0;

    signed_binary_to_decimal_digits_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .pad_zeros (pad_zeros),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .symbol    (symbol),
        .last      (last)
    );

    sb2d_digit_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .number          (number),
        .pad_zeros       (pad_zeros),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .symbol          (symbol),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .symbols_checked (symbols_checked)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Called right after a rising edge; returns right after the request is taken.
    task automatic send_request(input logic signed [31:0] value, input logic pad);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        number    <= value;
        pad_zeros <= pad;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
    endtask

    function automatic logic [31:0] draw_number();
        logic [31:0] r;
        logic [31:0] p;
        int unsigned n;
        r = $urandom;
        case ($urandom_range(5))
            0, 1: ;
            2: r = $urandom_range(999);
            3: r = -$urandom_range(999);
            4:
            begin
                p = 32'd1;
                n = $urandom_range(9);
                repeat (n) p = p * 32'd10;
                r = p + $urandom_range(2) - 32'd1;
                if ($urandom_range(1))
                    r = -r;
            end
            default:
            begin
                r = r >> $urandom_range(31);
                if ($urandom_range(1))
                    r = -r;
            end
        endcase
        return r;
    endfunction

    task automatic run_phase(input int idle_pct, input int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (PHASE_ITEMS)
            send_request(draw_number(), 1'($urandom_range(1)));
    endtask

    initial
    begin
        logic signed [31:0] directed[13];
        directed = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
                     32'sd999999999, 32'sd1000000000, -32'sd1000000000,
                     32'sd2147483647, -32'sd2147483648, 32'sd1234567890,
                     -32'sd987654321};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            send_request(directed[i], 1'b0);
            send_request(directed[i], 1'b1);
        end
        directed_sent = requests_sent;

        run_phase(0, 0);
        run_phase(73, 0);
        run_phase(0, 73);
        run_phase(27, 27);
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values (%0d directed, both pad settings) over four idle/stall phases.",
                 requests_sent, directed_sent);
        $display("Compared %0d output symbols, %0d mismatches.", symbols_checked, fail_count);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 8);
        $display("Timeout with %0d symbols still expected.", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/sb2d_pkg.sv
rtl/core/sb2d_cell.sv
rtl/core/sb2d_serializer.sv
rtl/core/signed_binary_to_decimal_digits_core.sv
tb/sv/sb2d_digit_checker.sv
tb/sv/testbench.sv
